/* rtl/nearest_point_field_lookup_top_defines.svh */
// Assertion macros shared by the nearest point lookup RTL
`ifndef NEAREST_POINT_FIELD_LOOKUP_TOP_DEFINES_SVH
`define NEAREST_POINT_FIELD_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define NPFL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("npfl assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define NPFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("npfl assertion failed");

`endif

/* rtl/npfl_pkg.sv */
// Package: types, codes and default sizes of the nearest point lookup
package npfl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int COORD_BITS_DEF  = 24;
    localparam int FIELD_BITS_DEF  = 24;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_APPENDED = 3'd2,
        ST_REPLACED = 3'd3,
        ST_DROPPED  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_VREAD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_scan_flags;

endpackage

/* rtl/npfl_ram.sv */
// Generic single-port-write, registered-read RAM
module npfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/npfl_scan.sv */
// Distance pipeline: squared distance per entry, best-entry and match tracking
module npfl_scan
    import npfl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_start,
    input  logic signed [COORD_BITS-1:0]                     i_qx,
    input  logic signed [COORD_BITS-1:0]                     i_qy,
    input  logic signed [COORD_BITS-1:0]                     i_qz,
    input  logic                                             i_vld,
    input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] i_idx,
    input  logic [3*COORD_BITS-1:0]                          i_coord,
    output t_scan_flags                                      o_flags,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] o_best_idx,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] o_hit_idx
);

    localparam int CB = COORD_BITS;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QW = 2 * CB;
    localparam int SW = 2 * CB + 2;

    logic signed [CB-1:0] cx, cy, cz;
    logic signed [CB:0]   dx, dy, dz;
    logic [QW-1:0]        sq_x, sq_y, sq_z;
    logic                 lex_lt, better;

    logic                 r_s1_vld, r_s2_vld, r_s3_vld;
    logic [AW-1:0]        r_s1_idx, r_s2_idx, r_s3_idx;
    logic signed [CB-1:0] r_s1_x, r_s1_y, r_s1_z, r_s2_x, r_s2_y, r_s2_z;
    logic signed [CB-1:0] r_s3_x, r_s3_y, r_s3_z;
    logic                 r_s1_eq, r_s2_eq, r_s3_eq;
    logic [CB-1:0]        r_s1_ax, r_s1_ay, r_s1_az;
    logic [QW-1:0]        r_s2_sx, r_s2_sy, r_s2_sz;
    logic [SW-1:0]        r_s3_sum;

    logic                 r_best_vld;
    logic [SW-1:0]        r_best_d;
    logic signed [CB-1:0] r_best_x, r_best_y, r_best_z;
    logic [AW-1:0]        r_best_idx;
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;

    assign cx = i_coord[3*CB-1:2*CB];
    assign cy = i_coord[2*CB-1:CB];
    assign cz = i_coord[CB-1:0];

    assign dx = {i_qx[CB-1], i_qx} - {cx[CB-1], cx};
    assign dy = {i_qy[CB-1], i_qy} - {cy[CB-1], cy};
    assign dz = {i_qz[CB-1], i_qz} - {cz[CB-1], cz};

    assign sq_x = r_s1_ax * r_s1_ax;
    assign sq_y = r_s1_ay * r_s1_ay;
    assign sq_z = r_s1_az * r_s1_az;

    always_comb begin
        if (r_s3_x != r_best_x) begin
            lex_lt = (r_s3_x < r_best_x);
        end else if (r_s3_y != r_best_y) begin
            lex_lt = (r_s3_y < r_best_y);
        end else begin
            lex_lt = (r_s3_z < r_best_z);
        end
        better = !r_best_vld || (r_s3_sum < r_best_d) || ((r_s3_sum == r_best_d) && lex_lt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (i_start) begin
                r_best_vld <= 1'b0;
                r_hit      <= 1'b0;
            end else if (r_s3_vld) begin
                if (better) begin
                    r_best_vld <= 1'b1;
                end
                if (r_s3_eq) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_idx;
        r_s1_x   <= cx;
        r_s1_y   <= cy;
        r_s1_z   <= cz;
        r_s1_eq  <= (cx == i_qx) && (cy == i_qy) && (cz == i_qz);
        r_s1_ax  <= dx[CB] ? CB'(-dx) : CB'(dx);
        r_s1_ay  <= dy[CB] ? CB'(-dy) : CB'(dy);
        r_s1_az  <= dz[CB] ? CB'(-dz) : CB'(dz);

        r_s2_idx <= r_s1_idx;
        r_s2_x   <= r_s1_x;
        r_s2_y   <= r_s1_y;
        r_s2_z   <= r_s1_z;
        r_s2_eq  <= r_s1_eq;
        r_s2_sx  <= sq_x;
        r_s2_sy  <= sq_y;
        r_s2_sz  <= sq_z;

        r_s3_idx <= r_s2_idx;
        r_s3_x   <= r_s2_x;
        r_s3_y   <= r_s2_y;
        r_s3_z   <= r_s2_z;
        r_s3_eq  <= r_s2_eq;
        r_s3_sum <= SW'(r_s2_sx) + SW'(r_s2_sy) + SW'(r_s2_sz);

        if (r_s3_vld && better) begin
            r_best_d   <= r_s3_sum;
            r_best_x   <= r_s3_x;
            r_best_y   <= r_s3_y;
            r_best_z   <= r_s3_z;
            r_best_idx <= r_s3_idx;
        end
        if (r_s3_vld && r_s3_eq && !r_hit) begin
            r_hit_idx <= r_s3_idx;
        end
    end

    assign o_flags.busy = r_s1_vld | r_s2_vld | r_s3_vld;
    assign o_flags.hit  = r_hit;
    assign o_best_idx   = r_best_idx;
    assign o_hit_idx    = r_hit_idx;

`include "nearest_point_field_lookup_top_defines.svh"

    `NPFL_ASSERT_NOW(a_hit_has_best, r_hit, r_best_vld)
    `NPFL_ASSERT_NEXT(a_start_clears, i_start, !r_hit && !r_best_vld)
    `NPFL_ASSERT_NEXT(a_pipe_moves, r_s1_vld && !i_start, r_s3_vld || r_s2_vld)

endmodule

/* rtl/nearest_point_field_lookup_top.sv */
// Top level: request sequencer, entry count, point and field memories, result register
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_mode, i_pos_x/y/z, i_load_bx/by/bz
//  out     | o_out_valid| i_out_ready | o_field_x/y/z, o_status
//
// A request over n stored entries steps through S_SCAN, S_DRAIN, S_COMMIT and S_DONE;
// the point memory delivers one entry a cycle into a four-stage read and distance
// pipeline that empties in S_DRAIN, and a query also reads the field memory in S_VREAD.
// An empty table skips S_SCAN and S_DRAIN. The next request is taken in S_IDLE, entered
// as the result register loads. Reset clears only the entry count and control.
// A request is taken while the previous result waits in the output register; the
// block stalls at the end of a request until that register is free.
module nearest_point_field_lookup_top
    import npfl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int FIELD_BITS  = FIELD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic signed [FIELD_BITS-1:0] i_load_bx,
    input  logic signed [FIELD_BITS-1:0] i_load_by,
    input  logic signed [FIELD_BITS-1:0] i_load_bz,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [FIELD_BITS-1:0] o_field_x,
    output logic signed [FIELD_BITS-1:0] o_field_y,
    output logic signed [FIELD_BITS-1:0] o_field_z,
    output logic [2:0]                   o_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int FB = FIELD_BITS;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_addr, n_addr;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_idx;

    logic                 r_mode;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic signed [FB-1:0] r_bx, r_by, r_bz;

    logic signed [FB-1:0] r_res_x, r_res_y, r_res_z;
    t_status              r_res_status;
    logic                 r_out_valid;
    logic signed [FB-1:0] r_out_x, r_out_y, r_out_z;
    t_status              r_out_status;

    logic                 in_acc, out_free, scan_last;
    logic                 coord_we, coord_re, vec_we, vec_re;
    logic [AW-1:0]        vec_addr, best_idx, hit_idx;
    logic [3*COORD_BITS-1:0] coord_rdata;
    logic [3*FB-1:0]      vec_rdata;
    t_scan_flags          scan_flags;
    t_status              commit_status;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign scan_last  = (CW'(r_addr) == r_count - CW'(1));

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_addr        = r_addr;
        coord_re      = 1'b0;
        coord_we      = 1'b0;
        vec_we        = 1'b0;
        vec_re        = 1'b0;
        vec_addr      = best_idx;
        commit_status = ST_FOUND;
        case (r_state)
            S_IDLE: begin
                n_addr = '0;
                if (in_acc) begin
                    n_state = (r_count == '0) ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                coord_re = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!scan_flags.busy && !r_rd_vld) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!r_mode) begin
                    n_state = S_DONE;
                    if (scan_flags.hit && r_count != '0) begin
                        commit_status = ST_REPLACED;
                        vec_we        = 1'b1;
                        vec_addr      = hit_idx;
                    end else if (r_count < CW'(TABLE_DEPTH)) begin
                        commit_status = ST_APPENDED;
                        coord_we      = 1'b1;
                        vec_we        = 1'b1;
                        vec_addr      = r_count[AW-1:0];
                        n_count       = r_count + CW'(1);
                    end else begin
                        commit_status = ST_DROPPED;
                    end
                end else if (r_count == '0) begin
                    commit_status = ST_EMPTY;
                    n_state       = S_DONE;
                end else begin
                    vec_re  = 1'b1;
                    n_state = S_VREAD;
                end
            end
            S_VREAD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_addr   <= n_addr;
            r_rd_vld <= coord_re;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (in_acc) begin
            r_mode <= i_mode;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
            r_bx   <= i_load_bx;
            r_by   <= i_load_by;
            r_bz   <= i_load_bz;
        end
        if (r_state == S_COMMIT) begin
            r_res_x      <= '0;
            r_res_y      <= '0;
            r_res_z      <= '0;
            r_res_status <= commit_status;
        end else if (r_state == S_VREAD) begin
            r_res_x <= vec_rdata[3*FB-1:2*FB];
            r_res_y <= vec_rdata[2*FB-1:FB];
            r_res_z <= vec_rdata[FB-1:0];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_x      <= r_res_x;
            r_out_y      <= r_res_y;
            r_out_z      <= r_res_z;
            r_out_status <= r_res_status;
        end
    end

    npfl_ram #(
        .WIDTH (3 * COORD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (coord_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_px, r_py, r_pz}),
        .i_re    (coord_re),
        .i_raddr (r_addr),
        .o_rdata (coord_rdata)
    );

    npfl_ram #(
        .WIDTH (3 * FB),
        .DEPTH (TABLE_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_addr),
        .i_wdata ({r_bx, r_by, r_bz}),
        .i_re    (vec_re),
        .i_raddr (vec_addr),
        .o_rdata (vec_rdata)
    );

    npfl_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_qx       (r_px),
        .i_qy       (r_py),
        .i_qz       (r_pz),
        .i_vld      (r_rd_vld),
        .i_idx      (r_rd_idx),
        .i_coord    (coord_rdata),
        .o_flags    (scan_flags),
        .o_best_idx (best_idx),
        .o_hit_idx  (hit_idx)
    );

    assign o_out_valid = r_out_valid;
    assign o_field_x   = r_out_x;
    assign o_field_y   = r_out_y;
    assign o_field_z   = r_out_z;
    assign o_status    = r_out_status;

`include "nearest_point_field_lookup_top_defines.svh"

    `NPFL_ASSERT_NOW(a_scan_nonempty, r_state == S_SCAN, r_count != '0)
    `NPFL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `NPFL_ASSERT_NEXT(a_append_counts, coord_we, r_count == $past(r_count) + CW'(1))

endmodule
